[hw/rtl/ffha_pkg.sv]
package ffha_pkg;

  localparam int FIELD_W  = 12;
  localparam int STATUS_W = 2;

  // Operation codes of a request item
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_CHK,
    ST_WALK,
    ST_CLAIM,
    ST_LEFT,
    ST_RESULT
  } state_t;

endpackage

[hw/rtl/ffha_if.sv]
interface ffha_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [ffha_pkg::FIELD_W-1:0] alloc_size;
  logic [ffha_pkg::FIELD_W-1:0] block_offset;

  modport source(output valid, output operation, output alloc_size, output block_offset,
                 input ready);
  modport sink(input valid, input operation, input alloc_size, input block_offset,
               output ready);
endinterface

interface ffha_res_if;
  logic                          valid;
  logic                          ready;
  logic [ffha_pkg::STATUS_W-1:0] status;
  logic [ffha_pkg::FIELD_W-1:0]  data_offset;

  modport source(output valid, output status, output data_offset, input ready);
  modport sink(input valid, input status, input data_offset, output ready);
endinterface

[hw/rtl/ffha_hdr_mem.sv]
// Header memory: one write port, one read port, registered read data.
module ffha_hdr_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/first_fit_heap_allocator.sv]
// Channel | Dir | Payload                                | Accepted when
// --------+-----+----------------------------------------+------------------------
// cmd     | in  | operation, alloc_size, block_offset     | cmd.valid & cmd.ready
// res     | out | status, data_offset                     | res.valid & res.ready
//
// Sequence: a free reads its header in the accept cycle and clears its used bit in
//   FREE_CHK; a formatted allocate walks the chain, one header read per cycle from the
//   header memory, up to HEAP_BYTES/2 headers, then writes the claim header and, on two
//   or more bytes left over, a header for the rest in LEFT; both end in RESULT.
// Reset: rst (synchronous) starts a clearing pass over all HEAP_BYTES headers, one header
//   a cycle; cmd.ready stays low until it ends.
// Stalls: the result register holds while res.ready is low; the next item is
//   accepted meanwhile and its result waits in the last state until the slot frees.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  ffha_cmd_if.sink    cmd,
  ffha_res_if.source  res
);

  localparam int ADDR_W = $clog2(HEAP_BYTES);
  localparam int HDR_W  = ADDR_W + 1;
  // Arithmetic width: holds walk addresses past the arena end and any request.
  localparam int VW = (ADDR_W + 2 > ffha_pkg::FIELD_W + 1) ? ADDR_W + 2
                                                            : ffha_pkg::FIELD_W + 1;
  localparam logic [VW-1:0]     HEAP_V   = VW'(HEAP_BYTES);
  localparam logic [VW-1:0]     ARENA_V  = VW'(HEAP_BYTES - 4);
  localparam logic [VW-1:0]     ONE_V    = VW'(1);
  localparam logic [VW-1:0]     TWO_V    = VW'(2);
  localparam logic [ADDR_W-1:0] FIRST_A  = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] LAST_A   = ADDR_W'(HEAP_BYTES - 1);

  ffha_pkg::state_t state, state_next;

  // Control registers
  logic [ADDR_W-1:0] clr_addr;
  logic              formatted;

  // Item registers
  logic [ADDR_W-1:0]            cur_i;
  logic [ADDR_W-1:0]            start_q;
  logic [VW-1:0]                space_q;
  logic                         run_q;
  logic [ffha_pkg::FIELD_W-1:0] req_q;
  logic                         op_q;
  logic [ADDR_W-1:0]            fa_q;
  logic                         fa_ok_q;
  logic [ffha_pkg::STATUS_W-1:0] stat_q;

  // Header memory port
  logic              m_we;
  logic [ADDR_W-1:0] m_waddr;
  logic [HDR_W-1:0]  m_wdata;
  logic [ADDR_W-1:0] m_raddr;
  logic [HDR_W-1:0]  m_rdata;

  ffha_hdr_mem #(
    .DEPTH  (HEAP_BYTES),
    .ADDR_W (ADDR_W),
    .DATA_W (HDR_W)
  ) u_hdr_mem (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // Datapath terms
  logic              accept;
  logic              res_load;
  logic [VW-1:0]     req_in_v;
  logic [VW-1:0]     off_v;
  logic [VW-1:0]     fa_v;
  logic              fa_in_ok;
  logic              hdr_used;
  logic [VW-1:0]     hdr_sz_v;
  logic [VW-1:0]     next_v;
  logic [VW-1:0]     cand_v;
  logic [VW-1:0]     reqq_v;
  logic              fit;
  logic              walk_end;
  logic [VW-1:0]     left_v;
  logic [VW-1:0]     left2_v;
  logic              left_one;
  logic              left_many;
  logic [VW-1:0]     left_at_v;
  logic              left_in;
  logic [VW-1:0]     claim_sz_v;
  logic [VW-1:0]     data_v;

  assign accept   = cmd.valid && cmd.ready;
  assign res_load = (state == ffha_pkg::ST_RESULT) && (!res.valid || res.ready);

  // Free address: header sits two bytes below the data offset
  assign req_in_v = {{(VW - ffha_pkg::FIELD_W){1'b0}}, cmd.alloc_size};
  assign off_v    = {{(VW - ffha_pkg::FIELD_W){1'b0}}, cmd.block_offset};
  assign fa_v     = off_v - TWO_V;
  assign fa_in_ok = (off_v >= TWO_V) && (fa_v < HEAP_V);

  // Walk step on the header just read at cur_i
  assign hdr_used = m_rdata[ADDR_W];
  assign hdr_sz_v = {{(VW - ADDR_W){1'b0}}, m_rdata[ADDR_W-1:0]};
  assign next_v   = {{(VW - ADDR_W){1'b0}}, cur_i} + hdr_sz_v + TWO_V;
  assign cand_v   = run_q ? (space_q + hdr_sz_v + TWO_V) : hdr_sz_v;
  assign reqq_v   = {{(VW - ffha_pkg::FIELD_W){1'b0}}, req_q};
  assign fit      = !hdr_used && (cand_v >= reqq_v);
  assign walk_end = next_v >= HEAP_V;

  // Claim of the run at start_q holding space_q bytes
  assign left_v     = space_q - reqq_v;
  assign left2_v    = left_v - TWO_V;
  assign left_one   = left_v == ONE_V;
  assign left_many  = left_v >= TWO_V;
  assign left_at_v  = {{(VW - ADDR_W){1'b0}}, start_q} + TWO_V + reqq_v;
  assign left_in    = left_at_v < HEAP_V;
  assign claim_sz_v = left_one ? (reqq_v + ONE_V) : reqq_v;
  assign data_v     = {{(VW - ADDR_W){1'b0}}, start_q} + TWO_V;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffha_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_A) state_next = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.operation == ffha_pkg::OP_FREE) begin
            state_next = ffha_pkg::ST_FREE_CHK;
          end else if (formatted) begin
            state_next = ffha_pkg::ST_WALK;
          end else if (req_in_v <= ARENA_V) begin
            state_next = ffha_pkg::ST_CLAIM;
          end else begin
            state_next = ffha_pkg::ST_RESULT;
          end
        end
      end
      ffha_pkg::ST_FREE_CHK: state_next = ffha_pkg::ST_RESULT;
      ffha_pkg::ST_WALK: begin
        if (fit) begin
          state_next = ffha_pkg::ST_CLAIM;
        end else if (walk_end) begin
          state_next = ffha_pkg::ST_RESULT;
        end
      end
      ffha_pkg::ST_CLAIM: begin
        state_next = left_many ? ffha_pkg::ST_LEFT : ffha_pkg::ST_RESULT;
      end
      ffha_pkg::ST_LEFT: state_next = ffha_pkg::ST_RESULT;
      ffha_pkg::ST_RESULT: begin
        if (res_load) state_next = ffha_pkg::ST_IDLE;
      end
      default: state_next = ffha_pkg::ST_CLEAR;
    endcase
  end

  // Outputs: handshake and header memory port
  always_comb begin
    cmd.ready = 1'b0;
    m_we      = 1'b0;
    m_waddr   = clr_addr;
    m_wdata   = '0;
    m_raddr   = FIRST_A;
    unique case (state)
      ffha_pkg::ST_CLEAR: begin
        m_we = 1'b1;
      end
      ffha_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        // Issue the first read in the accept cycle: free header or chain head
        if (cmd.operation == ffha_pkg::OP_FREE) m_raddr = fa_v[ADDR_W-1:0];
      end
      ffha_pkg::ST_FREE_CHK: begin
        m_we    = fa_ok_q && hdr_used;
        m_waddr = fa_q;
        m_wdata = {1'b0, m_rdata[ADDR_W-1:0]};
      end
      ffha_pkg::ST_WALK: begin
        // Read the following header straight from this one's size
        m_raddr = next_v[ADDR_W-1:0];
      end
      ffha_pkg::ST_CLAIM: begin
        m_we    = 1'b1;
        m_waddr = start_q;
        m_wdata = {1'b1, claim_sz_v[ADDR_W-1:0]};
      end
      ffha_pkg::ST_LEFT: begin
        m_we    = left_in;
        m_waddr = left_at_v[ADDR_W-1:0];
        m_wdata = {1'b0, left2_v[ADDR_W-1:0]};
      end
      ffha_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::ST_CLEAR;
      clr_addr  <= '0;
      formatted <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ffha_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      // Mark the arena formatted on the first allocate that fits it
      if (accept && cmd.operation == ffha_pkg::OP_ALLOC && !formatted &&
          req_in_v <= ARENA_V) begin
        formatted <= 1'b1;
      end
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    unique case (state)
      ffha_pkg::ST_IDLE: begin
        if (accept) begin
          op_q    <= cmd.operation;
          req_q   <= cmd.alloc_size;
          fa_q    <= fa_v[ADDR_W-1:0];
          fa_ok_q <= fa_in_ok;
          cur_i   <= FIRST_A;
          run_q   <= 1'b0;
          // First allocate claims the whole arena at offset 2
          start_q <= FIRST_A;
          space_q <= ARENA_V;
          stat_q  <= (cmd.operation == ffha_pkg::OP_FREE) ? ffha_pkg::STAT_BAD_FREE
                                                         : ffha_pkg::STAT_NO_SPACE;
        end
      end
      ffha_pkg::ST_FREE_CHK: begin
        if (fa_ok_q && hdr_used) stat_q <= ffha_pkg::STAT_OK;
      end
      ffha_pkg::ST_WALK: begin
        cur_i <= next_v[ADDR_W-1:0];
        if (hdr_used) begin
          // A used block ends any run
          run_q <= 1'b0;
        end else begin
          run_q   <= 1'b1;
          space_q <= cand_v;
          if (!run_q) start_q <= cur_i;
        end
      end
      ffha_pkg::ST_CLAIM: begin
        stat_q <= ffha_pkg::STAT_OK;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.status <= stat_q;
      if (stat_q == ffha_pkg::STAT_OK && op_q == ffha_pkg::OP_ALLOC) begin
        res.data_offset <= data_v[ffha_pkg::FIELD_W-1:0];
      end else begin
        res.data_offset <= '0;
      end
    end
  end

endmodule
